/* sv/bsfr_pkg.sv */
`default_nettype none
package bsfr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 4;
  localparam int CFG_W           = 64;
  localparam int WIN_DEPTH       = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                   : MAX_REPLACEMENT;
  localparam int WIN_AW          = $clog2(WIN_DEPTH);
  localparam int JOB_DEPTH       = 2;
  localparam int JOB_AW          = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int JOB_CW          = $clog2(JOB_DEPTH + 1);

  typedef enum logic [1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_idx_e;

  typedef logic [WIN_DEPTH-1:0][BYTE_W-1:0] bytes_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              string_last;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              run_last;
    logic              string_end;
  } out_t;

  // one request's worth of results: count bytes from the list, then end flag
  typedef struct packed {
    bytes_t           bytes;
    logic [LEN_W-1:0] count;
    logic             last;
  } job_t;

endpackage
`default_nettype wire

/* sv/bsfr_front.sv */
`default_nettype none
module bsfr_front import bsfr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire in_t               in_i,
  input  wire logic              cfg_we_i,
  input  wire cfg_idx_e          cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  output job_t                   job_o
);

  logic [CFG_W-1:0] pat_bytes_q, rep_bytes_q;
  logic [LEN_W-1:0] pat_len_q, rep_len_q;
  logic [LEN_W-1:0] fill_q, fill_d;
  bytes_t           win_q, win_d;

  logic [LEN_W-1:0] plen, rlen, fill_eff, fill_inc;
  bytes_t           win_ins, win_shift, pat_vec;
  logic             win_full, match;

  assign plen = (pat_len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_q;
  assign rlen = (rep_len_q > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT)
                                                      : rep_len_q;
  assign pat_vec = pat_bytes_q;

  always_comb begin
    fill_eff = fill_q;
    if ((fill_q >= plen) || (fill_q > LEN_W'(WIN_DEPTH - 1))) begin
      fill_eff = '0;
    end
    win_ins = win_q;
    win_ins[fill_eff[WIN_AW-1:0]] = in_i.data_byte;
    fill_inc  = fill_eff + LEN_W'(1);
    win_full  = (fill_inc == plen);
    win_shift = win_ins >> BYTE_W;
    match = win_full;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if ((LEN_W'(k) < plen) && (win_ins[k] != pat_vec[k])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    job_o.last  = in_i.string_last;
    job_o.bytes = win_ins;
    job_o.count = '0;
    fill_d = fill_q;
    win_d  = win_q;
    if (plen == '0) begin
      job_o.bytes    = '0;
      job_o.bytes[0] = in_i.data_byte;
      job_o.count    = LEN_W'(1);
    end else if (match) begin
      job_o.bytes = rep_bytes_q;
      job_o.count = rlen;
      fill_d      = '0;
    end else begin
      if (in_i.string_last) begin
        job_o.count = fill_inc;
      end else if (win_full) begin
        job_o.count = LEN_W'(1);
      end
      if (win_full) begin
        win_d  = win_shift;
        fill_d = fill_inc - LEN_W'(1);
      end else begin
        win_d  = win_ins;
        fill_d = fill_inc;
      end
      if (in_i.string_last) begin
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= '0;
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
      fill_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN_BYTES:      pat_bytes_q <= cfg_data_i;
        CFG_PATTERN_LENGTH: begin
          pat_len_q <= cfg_data_i[LEN_W-1:0];
          fill_q    <= '0;
        end
        CFG_REPLACEMENT_BYTES:  rep_bytes_q <= cfg_data_i;
        CFG_REPLACEMENT_LENGTH: rep_len_q   <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end else if (accept_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && (plen != '0)) begin
      win_q <= win_d;
    end
  end

endmodule
`default_nettype wire

/* sv/bsfr_jobq.sv */
`default_nettype none
module bsfr_jobq import bsfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire job_t wr_job_i,
  input  wire logic rd_i,
  output job_t      rd_job_o,
  output logic      full_o,
  output logic      empty_o
);

  job_t              mem_q [JOB_DEPTH];
  logic [JOB_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JOB_CW-1:0] cnt_q;
  logic              do_wr, do_rd;

  assign full_o   = (cnt_q == JOB_CW'(JOB_DEPTH));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  function automatic logic [JOB_AW-1:0] ptr_inc(logic [JOB_AW-1:0] p);
    return (p == JOB_AW'(JOB_DEPTH - 1)) ? '0 : p + JOB_AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_rd) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + JOB_CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - JOB_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule
`default_nettype wire

/* sv/bsfr_back.sv */
`default_nettype none
module bsfr_back import bsfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire job_t job_i,
  input  wire logic job_empty_i,
  output logic      job_rd_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output out_t      out_o
);

  logic [WIN_AW-1:0] idx_q, idx_d;
  logic              out_vld_q, out_vld_d;
  out_t              out_q, out_d;
  logic              can_load, at_end;

  assign can_load = !out_vld_q || pop_i;
  assign at_end   = ({1'b0, idx_q} + LEN_W'(1)) == job_i.count;

  always_comb begin
    job_rd_o  = 1'b0;
    idx_d     = idx_q;
    out_vld_d = out_vld_q && !pop_i;
    out_d     = out_q;
    if (!job_empty_i && can_load) begin
      if (job_i.count == '0) begin
        job_rd_o = 1'b1;
        if (job_i.last) begin
          out_vld_d        = 1'b1;
          out_d.out_byte   = '0;
          out_d.has_byte   = 1'b0;
          out_d.run_last   = 1'b1;
          out_d.string_end = 1'b1;
        end
      end else begin
        out_vld_d        = 1'b1;
        out_d.out_byte   = job_i.bytes[idx_q];
        out_d.has_byte   = 1'b1;
        out_d.run_last   = at_end;
        out_d.string_end = at_end && job_i.last;
        if (at_end) begin
          job_rd_o = 1'b1;
          idx_d    = '0;
        end else begin
          idx_d = idx_q + WIN_AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o = !out_vld_q;
  assign out_o   = out_q;

endmodule
`default_nettype wire

/* sv/byte_stream_find_replace.sv */
// Streaming find-and-replace on a byte string. Bytes enter through push/full,
// one per cycle while the queue has room; results leave through empty/pop in
// order. Each accepted byte is turned combinationally into a list of up to 8
// result bytes and queued (two requests deep); the back end plays a list out at
// one result per cycle while results are popped. Bytes that yield zero or one
// result let plain text flow at one byte per clock; a replacement or flush of n
// bytes at end of string keeps the back end busy until all n have left, and the
// input stalls once the queue fills. A request that yields nothing is still read
// by the back end. Results pass the queue and the output register to the ports.
// Writing pattern_length discards any bytes held in the match window.
`default_nettype none
module byte_stream_find_replace import bsfr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire in_t              in_data_i,
  output logic                  empty,
  input  wire logic             pop,
  output out_t                  out_data_o,
  input  wire logic             cfg_we_i,
  input  wire cfg_idx_e         cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  job_t job_in, job_out;
  logic accept, job_rd, job_empty;

  assign accept = push && !full;

  bsfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .job_o      (job_in)
  );

  bsfr_jobq u_jobq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_job_i (job_in),
    .rd_i     (job_rd),
    .rd_job_o (job_out),
    .full_o   (full),
    .empty_o  (job_empty)
  );

  bsfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_rd_o    (job_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_o       (out_data_o)
  );

  a_end_is_run_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.string_end) |-> out_data_o.run_last)
    else $error("string end without run_last");

  a_byteless_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.has_byte) |-> (out_data_o.string_end && out_data_o.out_byte == '0))
    else $error("byteless result that is not a clean end mark");

  a_job_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (job_in.count <= LEN_W'(WIN_DEPTH)))
    else $error("request lists too many bytes");

endmodule
`default_nettype wire
